// ----- rtl/drd_pkg.sv -----
// shared types, widths and register codes of the detection row decoder
`default_nettype none

package drd_pkg;

    // field widths
    localparam int COORD_IN_W  = 16;
    localparam int COORD_OUT_W = 20;
    localparam int SCALE_W     = 24;
    localparam int PAD_W       = 10;
    localparam int DIM_W       = 12;
    localparam int SCORE_W     = 16;
    localparam int CLASS_W     = 8;
    localparam int POINT_IN_W  = 2 * COORD_IN_W;
    localparam int POINT_OUT_W = 2 * COORD_OUT_W;

    // lane arithmetic
    localparam int FRAC_IN_W = 4;
    localparam int DIFF_W    = COORD_IN_W + 1;
    localparam int MAG_W     = COORD_IN_W;
    localparam int PROD_W    = MAG_W + SCALE_W;
    localparam int KP_SHIFT  = 16;
    localparam int QUOT_W    = PROD_W - KP_SHIFT;

    // keypoints and lanes
    localparam int KEYPOINT_COUNT = 4;
    localparam int RANK_W         = $clog2(KEYPOINT_COUNT);
    localparam int BOX_LANES      = 4;
    localparam int LANE_COUNT     = BOX_LANES + 2 * KEYPOINT_COUNT;

    // keypoint saturation limits, Q15.4
    localparam logic [COORD_OUT_W-1:0] KP_POS_LIMIT = 20'h7FFFF;
    localparam logic [COORD_OUT_W-1:0] KP_NEG_LIMIT = 20'h80000;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // register reset values
    localparam logic [SCALE_W-1:0] RST_INVERSE_SCALE   = 24'd65536;
    localparam logic [PAD_W-1:0]   RST_PAD_LEFT        = 10'd0;
    localparam logic [PAD_W-1:0]   RST_PAD_TOP         = 10'd0;
    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH     = 12'd640;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT    = 12'd640;
    localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd32768;

    // register index codes
    typedef enum logic [2:0] {
        REG_INVERSE_SCALE   = 3'd0,
        REG_PAD_LEFT        = 3'd1,
        REG_PAD_TOP         = 3'd2,
        REG_IMAGE_WIDTH     = 3'd3,
        REG_IMAGE_HEIGHT    = 3'd4,
        REG_SCORE_THRESHOLD = 3'd5
    } t_reg_index;

    // one mapped coordinate, signed Q15.4 held as raw bits
    typedef logic [COORD_OUT_W-1:0] t_coord;

    typedef struct packed {
        logic [SCALE_W-1:0] inverse_scale;
        logic [PAD_W-1:0]   pad_left;
        logic [PAD_W-1:0]   pad_top;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [SCORE_W-1:0] score_threshold;
    } t_cfg;

    typedef struct packed {
        logic load_prod;
        logic load_map;
    } t_lane_ctrl;

    typedef struct packed {
        logic [CLASS_W-1:0]     class_out;
        logic [SCORE_W-1:0]     score_out;
        logic [DIM_W-1:0]       box_x;
        logic [DIM_W-1:0]       box_y;
        logic [DIM_W-1:0]       box_width;
        logic [DIM_W-1:0]       box_height;
        logic [POINT_OUT_W-1:0] corner_top_left;
        logic [POINT_OUT_W-1:0] corner_top_right;
        logic [POINT_OUT_W-1:0] corner_bottom_right;
        logic [POINT_OUT_W-1:0] corner_bottom_left;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/drd_in_if.sv -----
// channel interface carrying one detector row
`default_nettype none

interface drd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [drd_pkg::COORD_IN_W-1:0] left_raw;
    logic signed [drd_pkg::COORD_IN_W-1:0] top_raw;
    logic signed [drd_pkg::COORD_IN_W-1:0] right_raw;
    logic signed [drd_pkg::COORD_IN_W-1:0] bottom_raw;
    logic [drd_pkg::SCORE_W-1:0]           score;
    logic [drd_pkg::CLASS_W-1:0]           class_index;
    logic [drd_pkg::POINT_IN_W-1:0]        point_a;
    logic [drd_pkg::POINT_IN_W-1:0]        point_b;
    logic [drd_pkg::POINT_IN_W-1:0]        point_c;
    logic [drd_pkg::POINT_IN_W-1:0]        point_d;

    modport source (
        output valid, left_raw, top_raw, right_raw, bottom_raw, score, class_index,
               point_a, point_b, point_c, point_d,
        input  ready
    );

    modport sink (
        input  valid, left_raw, top_raw, right_raw, bottom_raw, score, class_index,
               point_a, point_b, point_c, point_d,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/drd_out_if.sv -----
// channel interface carrying one decoded detection
`default_nettype none

interface drd_out_if;
    logic                            valid;
    logic                            ready;
    logic [drd_pkg::CLASS_W-1:0]     class_out;
    logic [drd_pkg::SCORE_W-1:0]     score_out;
    logic [drd_pkg::DIM_W-1:0]       box_x;
    logic [drd_pkg::DIM_W-1:0]       box_y;
    logic [drd_pkg::DIM_W-1:0]       box_width;
    logic [drd_pkg::DIM_W-1:0]       box_height;
    logic [drd_pkg::POINT_OUT_W-1:0] corner_top_left;
    logic [drd_pkg::POINT_OUT_W-1:0] corner_top_right;
    logic [drd_pkg::POINT_OUT_W-1:0] corner_bottom_right;
    logic [drd_pkg::POINT_OUT_W-1:0] corner_bottom_left;

    modport source (
        output valid, class_out, score_out, box_x, box_y, box_width, box_height,
               corner_top_left, corner_top_right, corner_bottom_right, corner_bottom_left,
        input  ready
    );

    modport sink (
        input  valid, class_out, score_out, box_x, box_y, box_width, box_height,
               corner_top_left, corner_top_right, corner_bottom_right, corner_bottom_left,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/drd_cfg.sv -----
// apb register file for scale, padding, image size and score threshold
`default_nettype none

module drd_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [drd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [drd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [drd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output drd_pkg::t_cfg                         o_cfg
);

    drd_pkg::t_cfg      r_cfg;
    drd_pkg::t_cfg      n_cfg;
    drd_pkg::t_reg_index w_index;
    logic               w_write;

    assign w_index = drd_pkg::t_reg_index'(paddr[drd_pkg::APB_ADDR_W-1:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    // write decode, value masked to the register width
    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (w_index)
                drd_pkg::REG_INVERSE_SCALE: begin
                    n_cfg.inverse_scale = pwdata[drd_pkg::SCALE_W-1:0];
                end
                drd_pkg::REG_PAD_LEFT: begin
                    n_cfg.pad_left = pwdata[drd_pkg::PAD_W-1:0];
                end
                drd_pkg::REG_PAD_TOP: begin
                    n_cfg.pad_top = pwdata[drd_pkg::PAD_W-1:0];
                end
                drd_pkg::REG_IMAGE_WIDTH: begin
                    n_cfg.image_width = pwdata[drd_pkg::DIM_W-1:0];
                end
                drd_pkg::REG_IMAGE_HEIGHT: begin
                    n_cfg.image_height = pwdata[drd_pkg::DIM_W-1:0];
                end
                drd_pkg::REG_SCORE_THRESHOLD: begin
                    n_cfg.score_threshold = pwdata[drd_pkg::SCORE_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    // register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inverse_scale   <= drd_pkg::RST_INVERSE_SCALE;
            r_cfg.pad_left        <= drd_pkg::RST_PAD_LEFT;
            r_cfg.pad_top         <= drd_pkg::RST_PAD_TOP;
            r_cfg.image_width     <= drd_pkg::RST_IMAGE_WIDTH;
            r_cfg.image_height    <= drd_pkg::RST_IMAGE_HEIGHT;
            r_cfg.score_threshold <= drd_pkg::RST_SCORE_THRESHOLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read mux
    always_comb begin
        case (w_index)
            drd_pkg::REG_INVERSE_SCALE: begin
                prdata = drd_pkg::APB_DATA_W'(r_cfg.inverse_scale);
            end
            drd_pkg::REG_PAD_LEFT: begin
                prdata = drd_pkg::APB_DATA_W'(r_cfg.pad_left);
            end
            drd_pkg::REG_PAD_TOP: begin
                prdata = drd_pkg::APB_DATA_W'(r_cfg.pad_top);
            end
            drd_pkg::REG_IMAGE_WIDTH: begin
                prdata = drd_pkg::APB_DATA_W'(r_cfg.image_width);
            end
            drd_pkg::REG_IMAGE_HEIGHT: begin
                prdata = drd_pkg::APB_DATA_W'(r_cfg.image_height);
            end
            drd_pkg::REG_SCORE_THRESHOLD: begin
                prdata = drd_pkg::APB_DATA_W'(r_cfg.score_threshold);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/drd_lane.sv -----
// one coordinate lane: pad removal, scale multiply, truncation and saturation
`default_nettype none

module drd_lane (
    input  wire logic                               i_clk,
    input  wire logic signed [drd_pkg::COORD_IN_W-1:0] i_raw,
    input  wire logic [drd_pkg::PAD_W-1:0]          i_pad,
    input  wire logic [drd_pkg::SCALE_W-1:0]        i_scale,
    input  wire drd_pkg::t_lane_ctrl                i_ctrl,
    output drd_pkg::t_coord                         o_coord
);

    logic [drd_pkg::DIFF_W-1:0]   w_diff;
    logic [drd_pkg::DIFF_W-1:0]   w_mag_full;
    logic [drd_pkg::MAG_W-1:0]    w_mag;
    logic                         w_neg;
    logic [drd_pkg::PROD_W-1:0]   n_prod;
    logic [drd_pkg::PROD_W-1:0]   r_prod;
    logic                         r_neg;
    logic [drd_pkg::QUOT_W-1:0]   w_quot;
    drd_pkg::t_coord              n_coord;
    drd_pkg::t_coord              r_coord;

    // subtract the pad in q.4 and split into sign and magnitude
    assign w_diff = {i_raw[drd_pkg::COORD_IN_W-1], i_raw}
                  - {{(drd_pkg::DIFF_W - drd_pkg::PAD_W - drd_pkg::FRAC_IN_W){1'b0}},
                     i_pad, {drd_pkg::FRAC_IN_W{1'b0}}};
    assign w_neg      = w_diff[drd_pkg::DIFF_W-1];
    assign w_mag_full = w_neg ? (~w_diff + drd_pkg::DIFF_W'(1)) : w_diff;
    assign w_mag      = w_mag_full[drd_pkg::MAG_W-1:0];

    // magnitude times inverse scale, exact q.20
    assign n_prod = w_mag * i_scale;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_prod) begin
            r_prod <= n_prod;
            r_neg  <= w_neg;
        end
    end

    // drop 16 fraction bits toward zero, saturate to signed 20 bits
    assign w_quot = r_prod[drd_pkg::PROD_W-1:drd_pkg::KP_SHIFT];

    always_comb begin
        if (r_neg) begin
            if (w_quot > drd_pkg::QUOT_W'(drd_pkg::KP_NEG_LIMIT)) begin
                n_coord = drd_pkg::KP_NEG_LIMIT;
            end else begin
                n_coord = ~w_quot[drd_pkg::COORD_OUT_W-1:0] + drd_pkg::COORD_OUT_W'(1);
            end
        end else begin
            if (w_quot > drd_pkg::QUOT_W'(drd_pkg::KP_POS_LIMIT)) begin
                n_coord = drd_pkg::KP_POS_LIMIT;
            end else begin
                n_coord = w_quot[drd_pkg::COORD_OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_map) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

`default_nettype wire

// ----- rtl/drd_merge.sv -----
// merge of lane results: box clamp, empty box check, keypoint ordering
`default_nettype none

module drd_merge (
    input  wire drd_pkg::t_coord             i_x1,
    input  wire drd_pkg::t_coord             i_y1,
    input  wire drd_pkg::t_coord             i_x2,
    input  wire drd_pkg::t_coord             i_y2,
    input  wire drd_pkg::t_coord             i_px [drd_pkg::KEYPOINT_COUNT],
    input  wire drd_pkg::t_coord             i_py [drd_pkg::KEYPOINT_COUNT],
    input  wire logic [drd_pkg::DIM_W-1:0]   i_image_width,
    input  wire logic [drd_pkg::DIM_W-1:0]   i_image_height,
    input  wire logic [drd_pkg::CLASS_W-1:0] i_class,
    input  wire logic [drd_pkg::SCORE_W-1:0] i_score,
    output drd_pkg::t_result                 o_result,
    output logic                             o_keep
);

    localparam int PIX_W = drd_pkg::COORD_OUT_W - 1 - drd_pkg::FRAC_IN_W;

    logic [drd_pkg::DIM_W-1:0]   w_x1;
    logic [drd_pkg::DIM_W-1:0]   w_y1;
    logic [drd_pkg::DIM_W-1:0]   w_x2;
    logic [drd_pkg::DIM_W-1:0]   w_y2;
    logic [drd_pkg::DIM_W:0]     w_w;
    logic [drd_pkg::DIM_W:0]     w_h;
    logic [drd_pkg::RANK_W-1:0]  w_rank [drd_pkg::KEYPOINT_COUNT];
    drd_pkg::t_coord             w_sx [drd_pkg::KEYPOINT_COUNT];
    drd_pkg::t_coord             w_sy [drd_pkg::KEYPOINT_COUNT];
    drd_pkg::t_coord             w_ox [drd_pkg::KEYPOINT_COUNT];
    drd_pkg::t_coord             w_oy [drd_pkg::KEYPOINT_COUNT];

    // whole pixels from a q15.4 value, clamped to [0, limit]
    function automatic logic [drd_pkg::DIM_W-1:0] to_pixel(
        input drd_pkg::t_coord v,
        input logic [drd_pkg::DIM_W-1:0] limit
    );
        logic [PIX_W-1:0] whole;
        whole = v[drd_pkg::COORD_OUT_W-2:drd_pkg::FRAC_IN_W];
        if (v[drd_pkg::COORD_OUT_W-1]) begin
            to_pixel = '0;
        end else if (whole > PIX_W'(limit)) begin
            to_pixel = limit;
        end else begin
            to_pixel = whole[drd_pkg::DIM_W-1:0];
        end
    endfunction

    // box corners and extent
    assign w_x1 = to_pixel(i_x1, i_image_width);
    assign w_y1 = to_pixel(i_y1, i_image_height);
    assign w_x2 = to_pixel(i_x2, i_image_width);
    assign w_y2 = to_pixel(i_y2, i_image_height);
    assign w_w  = {1'b0, w_x2} - {1'b0, w_x1};
    assign w_h  = {1'b0, w_y2} - {1'b0, w_y1};
    assign o_keep = !w_w[drd_pkg::DIM_W] && (w_w[drd_pkg::DIM_W-1:0] != '0)
                 && !w_h[drd_pkg::DIM_W] && (w_h[drd_pkg::DIM_W-1:0] != '0);

    // stable rank by y: earlier equal keys stay in front
    always_comb begin
        for (int i = 0; i < drd_pkg::KEYPOINT_COUNT; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < drd_pkg::KEYPOINT_COUNT; j++) begin
                if ((j < i && $signed(i_py[j]) <= $signed(i_py[i]))
                        || (j > i && $signed(i_py[j]) < $signed(i_py[i]))) begin
                    w_rank[i] = w_rank[i] + drd_pkg::RANK_W'(1);
                end
            end
        end
    end

    // place each point at its rank
    always_comb begin
        for (int r = 0; r < drd_pkg::KEYPOINT_COUNT; r++) begin
            w_sx[r] = '0;
            w_sy[r] = '0;
            for (int i = 0; i < drd_pkg::KEYPOINT_COUNT; i++) begin
                if (w_rank[i] == drd_pkg::RANK_W'(r)) begin
                    w_sx[r] = i_px[i];
                    w_sy[r] = i_py[i];
                end
            end
        end
    end

    // order each pair by x, swap only on strictly smaller x
    always_comb begin
        for (int k = 0; k < drd_pkg::KEYPOINT_COUNT; k += 2) begin
            if ($signed(w_sx[k+1]) < $signed(w_sx[k])) begin
                w_ox[k]   = w_sx[k+1];
                w_oy[k]   = w_sy[k+1];
                w_ox[k+1] = w_sx[k];
                w_oy[k+1] = w_sy[k];
            end else begin
                w_ox[k]   = w_sx[k];
                w_oy[k]   = w_sy[k];
                w_ox[k+1] = w_sx[k+1];
                w_oy[k+1] = w_sy[k+1];
            end
        end
    end

    // result fields
    always_comb begin
        o_result.class_out           = i_class;
        o_result.score_out           = i_score;
        o_result.box_x               = w_x1;
        o_result.box_y               = w_y1;
        o_result.box_width           = w_w[drd_pkg::DIM_W-1:0];
        o_result.box_height          = w_h[drd_pkg::DIM_W-1:0];
        o_result.corner_top_left     = {w_ox[0], w_oy[0]};
        o_result.corner_top_right    = {w_ox[1], w_oy[1]};
        o_result.corner_bottom_right = {w_ox[3], w_oy[3]};
        o_result.corner_bottom_left  = {w_ox[2], w_oy[2]};
    end

endmodule

`default_nettype wire

// ----- rtl/detection_row_decode_unit.sv -----
// top level of the detection row decoder: input stage, twelve lanes, merge, output register
//
//  channel   dir  handshake              payload
//  i_row     in   valid/ready transfer   box corners, score, class, four keypoints
//  o_det     out  valid/ready transfer   class, score, clamped box, ordered corners
//  apb       in   psel/penable/pwrite    six configuration registers, pready always high
//
// one row per cycle sustained while o_det is ready; a taken row passes the input register,
// lane multiply, lane truncate/saturate and merge into the output register in turn.
// the lane multiply stage sets the cycle time: one 16 x 24 product per coordinate.
// rows below the score threshold or with an empty box leave no result, only an empty slot.
// stalls on o_det back up stage by stage; empty stages keep filling while the output waits.
// synchronous active-low reset clears all stage valid bits and loads register defaults.
`default_nettype none

module detection_row_decode_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    drd_in_if.sink                                i_row,
    drd_out_if.source                             o_det,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [drd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [drd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [drd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);

    drd_pkg::t_cfg        w_cfg;
    drd_pkg::t_lane_ctrl  w_lane_ctrl;
    drd_pkg::t_result     w_result;
    drd_pkg::t_result     r_res;
    logic                 w_keep;

    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    logic                 r_vo;
    logic                 n_v1;
    logic                 w_ld1;
    logic                 w_ld2;
    logic                 w_ld3;
    logic                 w_ld4;

    logic [drd_pkg::COORD_IN_W-1:0] w_in_raw [drd_pkg::LANE_COUNT];
    logic [drd_pkg::COORD_IN_W-1:0] r_raw    [drd_pkg::LANE_COUNT];
    logic [drd_pkg::POINT_IN_W-1:0] w_points [drd_pkg::KEYPOINT_COUNT];
    drd_pkg::t_coord                w_coord  [drd_pkg::LANE_COUNT];
    drd_pkg::t_coord                w_px     [drd_pkg::KEYPOINT_COUNT];
    drd_pkg::t_coord                w_py     [drd_pkg::KEYPOINT_COUNT];

    logic [drd_pkg::CLASS_W-1:0] r_class1;
    logic [drd_pkg::CLASS_W-1:0] r_class2;
    logic [drd_pkg::CLASS_W-1:0] r_class3;
    logic [drd_pkg::SCORE_W-1:0] r_score1;
    logic [drd_pkg::SCORE_W-1:0] r_score2;
    logic [drd_pkg::SCORE_W-1:0] r_score3;

    // configuration registers
    drd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // stage enables: a stage loads when it is empty or its successor loads
    assign w_ld4 = !r_vo || o_det.ready;
    assign w_ld3 = !r_v3 || w_ld4;
    assign w_ld2 = !r_v2 || w_ld3;
    assign w_ld1 = !r_v1 || w_ld2;
    assign i_row.ready = w_ld1;

    assign w_lane_ctrl.load_prod = w_ld2;
    assign w_lane_ctrl.load_map  = w_ld3;

    // low-confidence rows are dropped at the input
    assign n_v1 = i_row.valid && (i_row.score >= w_cfg.score_threshold);

    // lane inputs: box corners first, then x/y of each keypoint
    assign w_points[0] = i_row.point_a;
    assign w_points[1] = i_row.point_b;
    assign w_points[2] = i_row.point_c;
    assign w_points[3] = i_row.point_d;
    assign w_in_raw[0] = i_row.left_raw;
    assign w_in_raw[1] = i_row.top_raw;
    assign w_in_raw[2] = i_row.right_raw;
    assign w_in_raw[3] = i_row.bottom_raw;

    for (genvar k = 0; k < drd_pkg::KEYPOINT_COUNT; k++) begin : g_points
        assign w_in_raw[drd_pkg::BOX_LANES + 2*k] =
            w_points[k][drd_pkg::POINT_IN_W-1:drd_pkg::COORD_IN_W];
        assign w_in_raw[drd_pkg::BOX_LANES + 2*k + 1] =
            w_points[k][drd_pkg::COORD_IN_W-1:0];
        assign w_px[k] = w_coord[drd_pkg::BOX_LANES + 2*k];
        assign w_py[k] = w_coord[drd_pkg::BOX_LANES + 2*k + 1];
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            for (int i = 0; i < drd_pkg::LANE_COUNT; i++) begin
                r_raw[i] <= w_in_raw[i];
            end
            r_class1 <= i_row.class_index;
            r_score1 <= i_row.score;
        end
    end

    // coordinate lanes, even lanes are x and odd lanes are y
    for (genvar g = 0; g < drd_pkg::LANE_COUNT; g++) begin : g_lane
        drd_lane u_lane (
            .i_clk   (i_clk),
            .i_raw   ($signed(r_raw[g])),
            .i_pad   ((g % 2 == 1) ? w_cfg.pad_top : w_cfg.pad_left),
            .i_scale (w_cfg.inverse_scale),
            .i_ctrl  (w_lane_ctrl),
            .o_coord (w_coord[g])
        );
    end

    // class and score follow the lane stages
    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_class2 <= r_class1;
            r_score2 <= r_score1;
        end
        if (w_ld3) begin
            r_class3 <= r_class2;
            r_score3 <= r_score2;
        end
    end

    // merge of lane results
    drd_merge u_merge (
        .i_x1           (w_coord[0]),
        .i_y1           (w_coord[1]),
        .i_x2           (w_coord[2]),
        .i_y2           (w_coord[3]),
        .i_px           (w_px),
        .i_py           (w_py),
        .i_image_width  (w_cfg.image_width),
        .i_image_height (w_cfg.image_height),
        .i_class        (r_class3),
        .i_score        (r_score3),
        .o_result       (w_result),
        .o_keep         (w_keep)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (w_ld4) begin
            r_res <= w_result;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_ld1) begin
                r_v1 <= n_v1;
            end
            if (w_ld2) begin
                r_v2 <= r_v1;
            end
            if (w_ld3) begin
                r_v3 <= r_v2;
            end
            if (w_ld4) begin
                r_vo <= r_v3 && w_keep;
            end
        end
    end

    // output channel
    assign o_det.valid               = r_vo;
    assign o_det.class_out           = r_res.class_out;
    assign o_det.score_out           = r_res.score_out;
    assign o_det.box_x               = r_res.box_x;
    assign o_det.box_y               = r_res.box_y;
    assign o_det.box_width           = r_res.box_width;
    assign o_det.box_height          = r_res.box_height;
    assign o_det.corner_top_left     = r_res.corner_top_left;
    assign o_det.corner_top_right    = r_res.corner_top_right;
    assign o_det.corner_bottom_right = r_res.corner_bottom_right;
    assign o_det.corner_bottom_left  = r_res.corner_bottom_left;

endmodule

`default_nettype wire

// ----- rtl/drd_checker.sv -----
// port-level assertions for the detection row decoder and their bind
`default_nettype none

module drd_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_valid,
    input wire logic                               i_ready,
    input wire logic [drd_pkg::CLASS_W-1:0]        i_class,
    input wire logic [drd_pkg::DIM_W-1:0]          i_width,
    input wire logic [drd_pkg::DIM_W-1:0]          i_height,
    input wire logic [drd_pkg::POINT_OUT_W-1:0]    i_tl,
    input wire logic [drd_pkg::POINT_OUT_W-1:0]    i_tr,
    input wire logic [drd_pkg::POINT_OUT_W-1:0]    i_br,
    input wire logic [drd_pkg::POINT_OUT_W-1:0]    i_bl
);

    localparam int CW = drd_pkg::COORD_OUT_W;

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its class and its top-left and bottom-right corners
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_class) && $stable(i_tl) && $stable(i_br))
        else $error("result payload changed while stalled");

    // empty boxes never leave the block
    a_box_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_width != '0 && i_height != '0)
        else $error("empty box transferred");

    // corners come out ordered: top pair above bottom pair, left of right
    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> $signed(i_tl[CW-1:0]) <= $signed(i_bl[CW-1:0])
                 && $signed(i_tr[CW-1:0]) <= $signed(i_br[CW-1:0])
                 && $signed(i_tl[2*CW-1:CW]) <= $signed(i_tr[2*CW-1:CW])
                 && $signed(i_bl[2*CW-1:CW]) <= $signed(i_br[2*CW-1:CW]))
        else $error("corner order broken");

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered after reset");

endmodule

bind detection_row_decode_unit drd_checker u_drd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_det.valid),
    .i_ready  (o_det.ready),
    .i_class  (o_det.class_out),
    .i_width  (o_det.box_width),
    .i_height (o_det.box_height),
    .i_tl     (o_det.corner_top_left),
    .i_tr     (o_det.corner_top_right),
    .i_br     (o_det.corner_bottom_right),
    .i_bl     (o_det.corner_bottom_left)
);

`default_nettype wire

// ----- verif/tb_detection_row_decode_unit.sv -----
// self-checking testbench for the detection row decoder: directed row table, then random rows
module tb_detection_row_decode_unit;
    import drd_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int IDLE_PERCENT  = 13;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int REG_COUNT     = 6;
    localparam int BOX_SHIFT     = 20;
    localparam longint KP_HIGH   = 524287;
    localparam longint KP_LOW    = -524288;

    // one detector row as driven on the input channel
    typedef struct {
        logic signed [COORD_IN_W-1:0] left_raw;
        logic signed [COORD_IN_W-1:0] top_raw;
        logic signed [COORD_IN_W-1:0] right_raw;
        logic signed [COORD_IN_W-1:0] bottom_raw;
        logic [SCORE_W-1:0]           score;
        logic [CLASS_W-1:0]           class_index;
        logic [POINT_IN_W-1:0]        point_a;
        logic [POINT_IN_W-1:0]        point_b;
        logic [POINT_IN_W-1:0]        point_c;
        logic [POINT_IN_W-1:0]        point_d;
    } t_row;

    // directed table entry; golden rows carry a hand-written outcome
    typedef struct {
        t_row    row;
        bit      golden;
        bit      keep;
        t_result want;
    } t_probe;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    drd_in_if  row_bus ();
    drd_out_if det_bus ();

    t_cfg    cfg_shadow;
    t_result pending_dets[$];
    t_probe  probes[$];
    int      errors;
    bit      steady;
    bit      hold_off_pending;

    detection_row_decode_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_bus),
        .o_det   (det_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- prediction

    // magnitude times inverse scale, shifted, truncated toward zero
    function automatic longint scaled(input longint diff, input int shift);
        longint unsigned mag;
        longint unsigned inv;
        longint unsigned q;
        inv = 64'(cfg_shadow.inverse_scale);
        mag = (diff < 0) ? -diff : diff;
        q = (mag * inv) >> shift;
        return (diff < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint box_edge(input logic signed [COORD_IN_W-1:0] raw,
                                        input logic [PAD_W-1:0] pad,
                                        input logic [DIM_W-1:0] limit);
        longint v;
        v = scaled(longint'(raw) - 16 * longint'(pad), BOX_SHIFT);
        if (v < 0) v = 0;
        if (v > longint'(limit)) v = longint'(limit);
        return v;
    endfunction

    function automatic longint map_keypoint(input logic signed [COORD_IN_W-1:0] raw,
                                            input logic [PAD_W-1:0] pad);
        longint v;
        v = scaled(longint'(raw) - 16 * longint'(pad), KP_SHIFT);
        if (v < KP_LOW) v = KP_LOW;
        if (v > KP_HIGH) v = KP_HIGH;
        return v;
    endfunction

    // full row decode; returns 0 when the row is dropped
    function automatic bit decode_row(input t_row r, output t_result d);
        longint                x1, y1, x2, y2, w, h;
        longint                kx[KEYPOINT_COUNT];
        longint                ky[KEYPOINT_COUNT];
        logic [POINT_IN_W-1:0] pts[KEYPOINT_COUNT];
        longint                tx, ty;
        int                    j;
        d = '0;
        if (r.score < cfg_shadow.score_threshold) return 0;
        x1 = box_edge(r.left_raw, cfg_shadow.pad_left, cfg_shadow.image_width);
        y1 = box_edge(r.top_raw, cfg_shadow.pad_top, cfg_shadow.image_height);
        x2 = box_edge(r.right_raw, cfg_shadow.pad_left, cfg_shadow.image_width);
        y2 = box_edge(r.bottom_raw, cfg_shadow.pad_top, cfg_shadow.image_height);
        w = x2 - x1;
        h = y2 - y1;
        if (w <= 0 || h <= 0) return 0;

        pts[0] = r.point_a;
        pts[1] = r.point_b;
        pts[2] = r.point_c;
        pts[3] = r.point_d;
        for (int i = 0; i < KEYPOINT_COUNT; i++) begin
            kx[i] = map_keypoint(pts[i][31:16], cfg_shadow.pad_left);
            ky[i] = map_keypoint(pts[i][15:0], cfg_shadow.pad_top);
        end

        // stable sort by y
        for (int i = 1; i < KEYPOINT_COUNT; i++) begin
            tx = kx[i];
            ty = ky[i];
            j = i - 1;
            while (j >= 0 && ky[j] > ty) begin
                kx[j + 1] = kx[j];
                ky[j + 1] = ky[j];
                j--;
            end
            kx[j + 1] = tx;
            ky[j + 1] = ty;
        end

        // left then right within the top and the bottom pair
        for (int i = 0; i < KEYPOINT_COUNT; i += 2) begin
            if (kx[i + 1] < kx[i]) begin
                tx = kx[i];
                ty = ky[i];
                kx[i] = kx[i + 1];
                ky[i] = ky[i + 1];
                kx[i + 1] = tx;
                ky[i + 1] = ty;
            end
        end

        d.class_out           = r.class_index;
        d.score_out           = r.score;
        d.box_x               = x1[DIM_W-1:0];
        d.box_y               = y1[DIM_W-1:0];
        d.box_width           = w[DIM_W-1:0];
        d.box_height          = h[DIM_W-1:0];
        d.corner_top_left     = {kx[0][19:0], ky[0][19:0]};
        d.corner_top_right    = {kx[1][19:0], ky[1][19:0]};
        d.corner_bottom_right = {kx[3][19:0], ky[3][19:0]};
        d.corner_bottom_left  = {kx[2][19:0], ky[2][19:0]};
        return 1;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [POINT_OUT_W-1:0] want,
                               input logic [POINT_OUT_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic compare_det(input t_result want);
        check_field("class_out", POINT_OUT_W'(want.class_out),
                    POINT_OUT_W'(det_bus.class_out));
        check_field("score_out", POINT_OUT_W'(want.score_out),
                    POINT_OUT_W'(det_bus.score_out));
        check_field("box_x", POINT_OUT_W'(want.box_x), POINT_OUT_W'(det_bus.box_x));
        check_field("box_y", POINT_OUT_W'(want.box_y), POINT_OUT_W'(det_bus.box_y));
        check_field("box_width", POINT_OUT_W'(want.box_width),
                    POINT_OUT_W'(det_bus.box_width));
        check_field("box_height", POINT_OUT_W'(want.box_height),
                    POINT_OUT_W'(det_bus.box_height));
        check_field("corner_top_left", want.corner_top_left, det_bus.corner_top_left);
        check_field("corner_top_right", want.corner_top_right, det_bus.corner_top_right);
        check_field("corner_bottom_right", want.corner_bottom_right,
                    det_bus.corner_bottom_right);
        check_field("corner_bottom_left", want.corner_bottom_left,
                    det_bus.corner_bottom_left);
    endtask

    // output transfer monitor
    always @(posedge i_clk) begin
        if (i_rst_n && det_bus.valid && det_bus.ready) begin
            if (pending_dets.size() == 0) begin
                errors++;
                $display("%0t: detection with none expected, class %0d score %0d",
                         $time, det_bus.class_out, det_bus.score_out);
            end else begin
                compare_det(pending_dets.pop_front());
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        det_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                det_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                det_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((row_bus.valid && row_bus.ready) || (det_bus.valid && det_bus.ready) ||
                (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- register port

    function automatic int reg_width(input int idx);
        case (idx)
            REG_INVERSE_SCALE:   return SCALE_W;
            REG_PAD_LEFT:        return PAD_W;
            REG_PAD_TOP:         return PAD_W;
            REG_IMAGE_WIDTH:     return DIM_W;
            REG_IMAGE_HEIGHT:    return DIM_W;
            REG_SCORE_THRESHOLD: return SCORE_W;
            default:             return 0;
        endcase
    endfunction

    function automatic logic [APB_DATA_W-1:0] shadow_reg(input int idx);
        case (idx)
            REG_INVERSE_SCALE:   return APB_DATA_W'(cfg_shadow.inverse_scale);
            REG_PAD_LEFT:        return APB_DATA_W'(cfg_shadow.pad_left);
            REG_PAD_TOP:         return APB_DATA_W'(cfg_shadow.pad_top);
            REG_IMAGE_WIDTH:     return APB_DATA_W'(cfg_shadow.image_width);
            REG_IMAGE_HEIGHT:    return APB_DATA_W'(cfg_shadow.image_height);
            REG_SCORE_THRESHOLD: return APB_DATA_W'(cfg_shadow.score_threshold);
            default:             return '0;
        endcase
    endfunction

    // write transfer; the shadow keeps only the register's own bits
    task automatic apb_write(input int idx, input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_INVERSE_SCALE:   cfg_shadow.inverse_scale   = data[SCALE_W-1:0];
            REG_PAD_LEFT:        cfg_shadow.pad_left        = data[PAD_W-1:0];
            REG_PAD_TOP:         cfg_shadow.pad_top         = data[PAD_W-1:0];
            REG_IMAGE_WIDTH:     cfg_shadow.image_width     = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT:    cfg_shadow.image_height    = data[DIM_W-1:0];
            REG_SCORE_THRESHOLD: cfg_shadow.score_threshold = data[SCORE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apb_read(input int idx, output logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        logic [APB_DATA_W-1:0] got;
        for (int i = 0; i < REG_COUNT; i++) begin
            apb_read(i, got);
            if (got !== shadow_reg(i)) begin
                errors++;
                $display("%0t: register %0d expected %h actual %h", $time, i,
                         shadow_reg(i), got);
            end
        end
    endtask

    // writes every register with junk above its width, then reads all back
    task automatic apply_settings(input t_cfg s);
        logic [APB_DATA_W-1:0] vals[REG_COUNT];
        logic [APB_DATA_W-1:0] junk;
        vals[REG_INVERSE_SCALE]   = APB_DATA_W'(s.inverse_scale);
        vals[REG_PAD_LEFT]        = APB_DATA_W'(s.pad_left);
        vals[REG_PAD_TOP]         = APB_DATA_W'(s.pad_top);
        vals[REG_IMAGE_WIDTH]     = APB_DATA_W'(s.image_width);
        vals[REG_IMAGE_HEIGHT]    = APB_DATA_W'(s.image_height);
        vals[REG_SCORE_THRESHOLD] = APB_DATA_W'(s.score_threshold);
        for (int i = 0; i < REG_COUNT; i++) begin
            junk = $urandom();
            apb_write(i, (junk << reg_width(i)) | vals[i]);
        end
        check_registers();
    endtask

    function automatic t_cfg pick_settings();
        t_cfg s;
        s.inverse_scale   = SCALE_W'(($urandom_range(0, 3) == 0)
                                     ? $urandom_range(1, 24'hFFFFFF)
                                     : $urandom_range(16384, 262143));
        s.pad_left        = PAD_W'($urandom_range(0, 640));
        s.pad_top         = PAD_W'($urandom_range(0, 640));
        s.image_width     = DIM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                               : $urandom_range(64, 4095));
        s.image_height    = DIM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                               : $urandom_range(64, 4095));
        s.score_threshold = SCORE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(0, 40000));
        return s;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [COORD_IN_W-1:0] sat16(input int v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[COORD_IN_W-1:0];
    endfunction

    function automatic logic [POINT_IN_W-1:0] pt(input int x, input int y);
        return {x[15:0], y[15:0]};
    endfunction

    function automatic logic [POINT_OUT_W-1:0] corner(input int x, input int y);
        return {x[19:0], y[19:0]};
    endfunction

    function automatic t_row row_of(input int l, input int t, input int rt, input int b,
                                    input int sc, input int cl,
                                    input logic [POINT_IN_W-1:0] pa,
                                    input logic [POINT_IN_W-1:0] pb,
                                    input logic [POINT_IN_W-1:0] pc,
                                    input logic [POINT_IN_W-1:0] pd);
        t_row r;
        r.left_raw    = l[15:0];
        r.top_raw     = t[15:0];
        r.right_raw   = rt[15:0];
        r.bottom_raw  = b[15:0];
        r.score       = sc[15:0];
        r.class_index = cl[7:0];
        r.point_a     = pa;
        r.point_b     = pb;
        r.point_c     = pc;
        r.point_d     = pd;
        return r;
    endfunction

    function automatic t_result det_of(input int cl, input int sc, input int bx, input int by,
                                       input int bw, input int bh,
                                       input logic [POINT_OUT_W-1:0] tl,
                                       input logic [POINT_OUT_W-1:0] tr,
                                       input logic [POINT_OUT_W-1:0] br,
                                       input logic [POINT_OUT_W-1:0] bl);
        t_result d;
        d.class_out           = cl[7:0];
        d.score_out           = sc[15:0];
        d.box_x               = bx[11:0];
        d.box_y               = by[11:0];
        d.box_width           = bw[11:0];
        d.box_height          = bh[11:0];
        d.corner_top_left     = tl;
        d.corner_top_right    = tr;
        d.corner_bottom_right = br;
        d.corner_bottom_left  = bl;
        return d;
    endfunction

    task automatic add_probe(input t_row r, input bit golden, input bit keep,
                             input t_result want);
        t_probe p;
        p.row    = r;
        p.golden = golden;
        p.keep   = keep;
        p.want   = want;
        probes.insert(probes.size(), p);
    endtask

    // directed rows at reset settings: unit scale, no pad, 640 x 640, threshold one half
    task automatic load_probes();
        logic [POINT_IN_W-1:0] z;
        z = '0;
        // score one below threshold
        add_probe(row_of(160, 320, 1760, 3520, 32767, 1, z, z, z, z), 1, 0, '0);
        // score at threshold, keypoints shuffled
        add_probe(row_of(160, 320, 1760, 3520, 32768, 7, pt(1760, 3520), pt(160, 320),
                         pt(160, 3520), pt(1760, 320)), 1, 1,
                  det_of(7, 32768, 10, 20, 100, 200, corner(160, 320), corner(1760, 320),
                         corner(1760, 3520), corner(160, 3520)));
        // all fields at their extremes
        add_probe(row_of(-32768, -32768, 32767, 32767, 65535, 255, pt(32767, 32767),
                         pt(-32768, -32768), pt(32767, -32768), pt(-32768, 32767)), 1, 1,
                  det_of(255, 65535, 0, 0, 640, 640, corner(-32768, -32768),
                         corner(32767, -32768), corner(32767, 32767), corner(-32768, 32767)));
        // empty boxes: zero width, negative width, zero height
        add_probe(row_of(1600, 0, 1600, 1600, 65535, 2, z, z, z, z), 1, 0, '0);
        add_probe(row_of(3200, 0, 1600, 1600, 65535, 2, z, z, z, z), 1, 0, '0);
        add_probe(row_of(0, 800, 1600, 800, 65535, 2, z, z, z, z), 1, 0, '0);
        // box clamped away on the right and on the left
        add_probe(row_of(11000, 0, 12000, 1600, 65535, 2, z, z, z, z), 1, 0, '0);
        add_probe(row_of(-3000, 0, -100, 1600, 65535, 2, z, z, z, z), 1, 0, '0);
        // zero score
        add_probe(row_of(160, 320, 1760, 3520, 0, 0, z, z, z, z), 1, 0, '0);
        // partial clamp on the left and right edges
        add_probe(row_of(-800, 8, 16000, 10239, 40000, 3, z, z, z, z), 1, 1,
                  det_of(3, 40000, 0, 0, 640, 639, '0, '0, '0, '0));
        // smallest box
        add_probe(row_of(16, 16, 32, 32, 50000, 4, z, z, z, z), 1, 1,
                  det_of(4, 50000, 1, 1, 1, 1, '0, '0, '0, '0));
        // keypoint ties: equal y, identical points, equal x within a pair
        add_probe(row_of(0, 0, 1600, 1600, 65535, 5, pt(64, 0), pt(48, 0), pt(32, 0),
                         pt(16, 0)), 0, 0, '0);
        add_probe(row_of(0, 0, 1600, 1600, 65535, 6, pt(100, 200), pt(100, 200),
                         pt(100, 200), pt(100, 200)), 0, 0, '0);
        add_probe(row_of(0, 0, 1600, 1600, 65535, 8, pt(50, 10), pt(50, 20), pt(-30, 90),
                         pt(-30, 80)), 0, 0, '0);
        // fractional edges truncated toward zero
        add_probe(row_of(-15, 15, 17, 33, 65535, 9, pt(-1, -17), pt(15, -15), pt(17, 1),
                         pt(-16, 31)), 0, 0, '0);
    endtask

    // mostly well-formed rows around the current pad, some broken, some noise
    function automatic t_row compose_row();
        t_row r;
        int   x0, y0, x1, y1, jit, j, tmp;
        int   cx[KEYPOINT_COUNT];
        int   cy[KEYPOINT_COUNT];
        int   order[KEYPOINT_COUNT];
        logic [POINT_IN_W-1:0] pts[KEYPOINT_COUNT];
        if ($urandom_range(0, 99) < 20) begin
            r.left_raw    = COORD_IN_W'($urandom());
            r.top_raw     = COORD_IN_W'($urandom());
            r.right_raw   = COORD_IN_W'($urandom());
            r.bottom_raw  = COORD_IN_W'($urandom());
            r.score       = SCORE_W'($urandom());
            r.class_index = CLASS_W'($urandom());
            r.point_a     = $urandom();
            r.point_b     = $urandom();
            r.point_c     = $urandom();
            r.point_d     = $urandom();
            return r;
        end
        x0 = 16 * int'(cfg_shadow.pad_left) + int'($urandom_range(0, 6000)) - 400;
        y0 = 16 * int'(cfg_shadow.pad_top) + int'($urandom_range(0, 6000)) - 400;
        x1 = x0 + int'($urandom_range(0, 6000)) - 60;
        y1 = y0 + int'($urandom_range(0, 6000)) - 60;
        cx = '{x0, x1, x1, x0};
        cy = '{y0, y0, y1, y1};
        for (int k = 0; k < KEYPOINT_COUNT; k++) order[k] = k;
        for (int k = KEYPOINT_COUNT - 1; k > 0; k--) begin
            j = int'($urandom_range(0, k));
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < KEYPOINT_COUNT; k++) begin
            // exact corners now and then, so that ties come up
            jit = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 80)) - 40;
            pts[k] = {sat16(cx[order[k]] + jit), sat16(cy[order[k]] - jit)};
        end
        r.left_raw    = sat16(x0);
        r.top_raw     = sat16(y0);
        r.right_raw   = sat16(x1);
        r.bottom_raw  = sat16(y1);
        r.score       = SCORE_W'(($urandom_range(0, 99) < 85)
                      ? $urandom_range(cfg_shadow.score_threshold, 65535) : $urandom());
        r.class_index = CLASS_W'($urandom());
        r.point_a     = pts[0];
        r.point_b     = pts[1];
        r.point_c     = pts[2];
        r.point_d     = pts[3];
        return r;
    endfunction

    // offer one row until transferred, then record what it should produce
    task automatic send_row(input t_row r, input bit golden, input bit keep,
                            input t_result want);
        t_result d;
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            row_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        row_bus.valid       <= 1'b1;
        row_bus.left_raw    <= r.left_raw;
        row_bus.top_raw     <= r.top_raw;
        row_bus.right_raw   <= r.right_raw;
        row_bus.bottom_raw  <= r.bottom_raw;
        row_bus.score       <= r.score;
        row_bus.class_index <= r.class_index;
        row_bus.point_a     <= r.point_a;
        row_bus.point_b     <= r.point_b;
        row_bus.point_c     <= r.point_c;
        row_bus.point_d     <= r.point_d;
        do @(posedge i_clk); while (!row_bus.ready);
        if (golden) begin
            if (keep) pending_dets.insert(pending_dets.size(), want);
        end else if (decode_row(r, d)) begin
            pending_dets.insert(pending_dets.size(), d);
        end
    endtask

    task automatic send_random(input int count);
        repeat (count) send_row(compose_row(), 0, 0, '0);
    endtask

    // stop offering, wait for every expected detection, then let dropped rows clear
    task automatic drain();
        row_bus.valid <= 1'b0;
        while (pending_dets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // main sequence
    initial begin : stimulus
        t_cfg s;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        row_bus.valid       = 1'b0;
        row_bus.left_raw    = '0;
        row_bus.top_raw     = '0;
        row_bus.right_raw   = '0;
        row_bus.bottom_raw  = '0;
        row_bus.score       = '0;
        row_bus.class_index = '0;
        row_bus.point_a     = '0;
        row_bus.point_b     = '0;
        row_bus.point_c     = '0;
        row_bus.point_d     = '0;
        errors              = 0;
        steady              = 1'b0;
        hold_off_pending    = 1'b0;
        cfg_shadow.inverse_scale   = RST_INVERSE_SCALE;
        cfg_shadow.pad_left        = RST_PAD_LEFT;
        cfg_shadow.pad_top         = RST_PAD_TOP;
        cfg_shadow.image_width     = RST_IMAGE_WIDTH;
        cfg_shadow.image_height    = RST_IMAGE_HEIGHT;
        cfg_shadow.score_threshold = RST_SCORE_THRESHOLD;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_registers();

        // directed table at reset settings
        load_probes();
        foreach (probes[k])
            send_row(probes[k].row, probes[k].golden, probes[k].keep, probes[k].want);

        // random at reset settings, with the long output hold-off and a steady stretch
        send_random(150);
        hold_off_pending = 1'b1;
        send_random(100);
        steady = 1'b1;
        send_random(150);
        steady = 1'b0;
        drain();

        // unmapped indexes must leave the registers alone
        apb_write(REG_COUNT, $urandom());
        apb_write(REG_COUNT + 1, $urandom());

        // upper extremes: keypoints saturate
        s.inverse_scale   = 24'hFFFFFF;
        s.pad_left        = 10'd640;
        s.pad_top         = 10'd640;
        s.image_width     = 12'd4095;
        s.image_height    = 12'd4095;
        s.score_threshold = 16'd0;
        apply_settings(s);
        send_random(150);
        drain();

        // lower extremes
        s.inverse_scale   = 24'd1;
        s.pad_left        = 10'd0;
        s.pad_top         = 10'd0;
        s.image_width     = 12'd1;
        s.image_height    = 12'd1;
        s.score_threshold = 16'hFFFF;
        apply_settings(s);
        send_random(40);
        drain();

        // zero inverse scale: every box empty
        s.inverse_scale   = 24'd0;
        s.pad_left        = 10'd320;
        s.pad_top         = 10'd320;
        s.image_width     = 12'd640;
        s.image_height    = 12'd640;
        s.score_threshold = 16'd0;
        apply_settings(s);
        send_random(40);
        drain();

        // random settings
        repeat (8) begin
            apply_settings(pick_settings());
            send_random(140);
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
